### sv/twcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package twcm_pkg;
  localparam int TEX_WIDTH  = 64;
  localparam int TEX_HEIGHT = 64;
  localparam int TXW = $clog2(TEX_WIDTH);
  localparam int TYW = $clog2(TEX_HEIGHT);
  localparam int QDEPTH = 2;
  localparam int STEP_MAX = 23'h7FFFFF;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_SKY    = 3'd2;
  localparam logic [2:0] CFG_GROUND = 3'd3;
  localparam logic [2:0] CFG_FLATC  = 3'd4;
  localparam logic [2:0] CFG_FLATF  = 3'd5;

  localparam logic [2:0] SRC_SKY     = 3'd0;
  localparam logic [2:0] SRC_CEILTEX = 3'd1;
  localparam logic [2:0] SRC_NORTH   = 3'd2;
  localparam logic [2:0] SRC_FLOOR   = 3'd6;
  localparam logic [2:0] SRC_GROUND  = 3'd7;

  typedef enum logic [1:0] {
    RG_CEIL  = 2'd0,
    RG_WALL  = 2'd1,
    RG_FLOOR = 2'd2
  } region_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_MUL  = 2'd2
  } bstate_t;

  typedef struct packed {
    logic [10:0] column;
    logic [10:0] row;
    logic        hit_side;
    logic [22:0] pos_x;
    logic [22:0] pos_y;
    logic [17:0] ray_dir_x;
    logic [17:0] ray_dir_y;
    logic [23:0] perp_dist;
    logic [15:0] line_height;
    logic [10:0] draw_start;
    region_t     region;
    logic        start;
  } qitem_t;
endpackage
`default_nettype wire

### sv/twcm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module twcm_front import twcm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [10:0] in_column,
  input  wire logic [10:0] in_row,
  input  wire logic        in_hit_side,
  input  wire logic [22:0] in_pos_x,
  input  wire logic [22:0] in_pos_y,
  input  wire logic signed [17:0] in_ray_dir_x,
  input  wire logic signed [17:0] in_ray_dir_y,
  input  wire logic [23:0] in_perp_dist,
  input  wire logic [15:0] in_line_height,
  input  wire logic [10:0] in_draw_start,
  input  wire logic [10:0] in_draw_end,
  output logic             q_valid,
  output qitem_t           q_item,
  input  wire logic        q_pop
);
  qitem_t mem_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp_r, rp_r;
  logic [$clog2(QDEPTH):0]   cnt_r, cnt_nxt;
  qitem_t it;
  logic push;

  always_comb begin
    it.column      = in_column;
    it.row         = in_row;
    it.hit_side    = in_hit_side;
    it.pos_x       = in_pos_x;
    it.pos_y       = in_pos_y;
    it.ray_dir_x   = in_ray_dir_x;
    it.ray_dir_y   = in_ray_dir_y;
    it.perp_dist   = in_perp_dist;
    it.line_height = in_line_height;
    it.draw_start  = in_draw_start;
    it.start       = (in_row == 11'd0);
    if (in_row < in_draw_start) it.region = RG_CEIL;
    else if (in_row <= in_draw_end) it.region = RG_WALL;
    else it.region = RG_FLOOR;
  end

  assign in_stall = (cnt_r == QDEPTH[$clog2(QDEPTH):0]);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rp_r];
  assign cnt_nxt  = cnt_r + {{$clog2(QDEPTH){1'b0}}, push}
                          - {{$clog2(QDEPTH){1'b0}}, q_pop};

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= it;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QDEPTH[$clog2(QDEPTH):0]) else $error("queue overflow");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop of empty queue");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && !q_pop) |=> in_stall) else $error("full lost");
endmodule
`default_nettype wire

### sv/twcm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module twcm_back import twcm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        q_valid,
  input  wire qitem_t      q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [21:0]      out_fb_address,
  output logic [2:0]       out_source,
  output logic [5:0]       out_tex_x,
  output logic [5:0]       out_tex_y,
  output logic [23:0]      out_flat_color,
  output logic [23:0]      out_depth,
  output logic             out_last
);
  logic [11:0] sw_r, sh_r;
  logic [23:0] sky_r, gnd_r;
  logic        fc_r, ff_r;

  logic [22:0]  step_r;
  logic [31:0]  tpos_r;
  logic [TXW-1:0] wcol_r;
  logic [1:0]   face_r;

  bstate_t st_r, st_nxt;
  logic [4:0]  dcnt_r;
  logic [16:0] rem_r;
  logic [22:0] quo_r;
  logic [15:0] lh_r;
  logic        setup_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= 12'd640; sh_r <= 12'd480; sky_r <= '0; gnd_r <= '0;
      fc_r <= 1'b1; ff_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  sw_r  <= cfg_data[11:0];
        CFG_HEIGHT: sh_r  <= cfg_data[11:0];
        CFG_SKY:    sky_r <= cfg_data;
        CFG_GROUND: gnd_r <= cfg_data;
        CFG_FLATC:  fc_r  <= cfg_data[0];
        CFG_FLATF:  ff_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // wall hit fraction
  logic signed [17:0] rdir;
  logic signed [42:0] prod;
  logic [22:0] pos;
  logic [31:0] frac;
  logic [TXW-1:0] colr;
  logic mirror;
  always_comb begin
    rdir  = q_item.hit_side ? q_item.ray_dir_x : q_item.ray_dir_y;
    pos   = q_item.hit_side ? q_item.pos_x : q_item.pos_y;
    prod  = $signed({1'b0, q_item.perp_dist}) * rdir;
    frac  = prod[31:0] + {pos[15:0], 16'd0};
    colr  = frac[31 -: TXW];
    mirror = q_item.hit_side ? q_item.ray_dir_y[17] : !q_item.ray_dir_x[17];
    if (mirror) colr = ~colr;
  end

  // restoring divider, one quotient bit per cycle, MSB first
  localparam logic [22:0] NUM = 23'(TEX_WIDTH << 16);
  logic [16:0] trial;
  always_comb trial = {rem_r[15:0], NUM[dcnt_r]};

  logic signed [16:0] offs;
  logic signed [40:0] pmul;
  always_comb begin
    offs = $signed({6'b0, q_item.draw_start}) - $signed({6'b0, sh_r[11:1]})
         + $signed({2'b0, lh_r[15:1]});
    pmul = offs * $signed({1'b0, quo_r});
  end

  logic busy_fire, fire;
  assign fire = q_valid && (!q_item.start || setup_done) && (!out_valid || !out_stall);
  assign q_pop = fire;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid && q_item.start && !setup_done) st_nxt = ST_DIV;
      ST_DIV:  if (dcnt_r == 5'd0) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end
  assign busy_fire = (st_r == ST_MUL);

  logic done_r;
  assign setup_done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; done_r <= 1'b0;
      step_r <= '0; tpos_r <= '0; wcol_r <= '0; face_r <= '0;
      dcnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: if (q_valid && q_item.start && !done_r) begin
          lh_r   <= (q_item.line_height == 16'd0) ? 16'd1 : q_item.line_height;
          rem_r  <= '0; quo_r <= '0; dcnt_r <= 5'd22;
          wcol_r <= colr;
          face_r <= q_item.hit_side ? (q_item.ray_dir_y[17] ? 2'd0 : 2'd1)
                                    : (q_item.ray_dir_x[17] ? 2'd2 : 2'd3);
        end
        ST_DIV: begin
          if (trial >= {1'b0, lh_r}) begin
            rem_r <= trial - {1'b0, lh_r};
            quo_r <= {quo_r[21:0], 1'b1};
          end else begin
            rem_r <= trial;
            quo_r <= {quo_r[21:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 5'd1;
        end
        ST_MUL: begin
          step_r <= quo_r;
          tpos_r <= pmul[31:0];
          done_r <= 1'b1;
        end
        default: ;
      endcase
      if (fire) begin
        if (q_item.region == RG_WALL || (q_item.region == RG_CEIL && !fc_r)
            || (q_item.region == RG_FLOOR && !ff_r))
          tpos_r <= tpos_r + {9'd0, step_r};
        if (q_item.start) done_r <= 1'b0;
      end
    end
  end

  // output register
  logic [22:0] addr_full;
  always_comb addr_full = {12'd0, q_item.row} * {11'd0, sw_r} + {12'd0, q_item.column};

  logic [2:0]  src_c;
  logic [5:0]  tx_c, ty_c;
  logic [23:0] fcol_c;
  always_comb begin
    src_c  = SRC_SKY;
    tx_c   = 6'(wcol_r);
    ty_c   = 6'(tpos_r[16 +: TYW]);
    fcol_c = '0;
    case (q_item.region)
      RG_CEIL: if (fc_r) begin
        src_c = SRC_SKY; fcol_c = sky_r; tx_c = '0; ty_c = '0;
      end else src_c = SRC_CEILTEX;
      RG_WALL: src_c = SRC_NORTH + {1'b0, face_r};
      default: if (ff_r) begin
        src_c = SRC_GROUND; fcol_c = gnd_r; tx_c = '0; ty_c = '0;
      end else src_c = SRC_FLOOR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (fire) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_fb_address <= addr_full[21:0];
      out_depth      <= q_item.perp_dist;
      out_last       <= (sh_r != 12'd0) && ({1'b0, q_item.row} == sh_r - 12'd1);
      out_tex_x      <= tx_c;
      out_tex_y      <= ty_c;
      out_flat_color <= fcol_c;
      out_source     <= src_c;
    end
  end

  a_nofire: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !fire) else $error("item during setup");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_fire |=> done_r) else $error("setup not flagged");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

### sv/textured_wall_column_mapper.sv
`timescale 1ns / 1ps
`default_nettype none
// Pixel path: queue, then output register. Row 0 first waits for the
// per-column setup (step divider, one multiply, one issue).
// Throughput: one pixel per cycle within a column while out_stall is low.
// Reset (rst_n sync low): registers to defaults, column state to zero,
// queue and output empty.
module textured_wall_column_mapper import twcm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [10:0] in_column,
  input  wire logic [10:0] in_row,
  input  wire logic        in_hit_side,
  input  wire logic [22:0] in_pos_x,
  input  wire logic [22:0] in_pos_y,
  input  wire logic signed [17:0] in_ray_dir_x,
  input  wire logic signed [17:0] in_ray_dir_y,
  input  wire logic [23:0] in_perp_dist,
  input  wire logic [15:0] in_line_height,
  input  wire logic [10:0] in_draw_start,
  input  wire logic [10:0] in_draw_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [21:0]      out_fb_address,
  output logic [2:0]       out_source,
  output logic [5:0]       out_tex_x,
  output logic [5:0]       out_tex_y,
  output logic [23:0]      out_flat_color,
  output logic [23:0]      out_depth,
  output logic             out_last
);
  logic   q_valid, q_pop;
  qitem_t q_item;

  twcm_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_column, .in_row, .in_hit_side,
    .in_pos_x, .in_pos_y, .in_ray_dir_x, .in_ray_dir_y, .in_perp_dist,
    .in_line_height, .in_draw_start, .in_draw_end,
    .q_valid, .q_item, .q_pop
  );

  twcm_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .q_valid, .q_item, .q_pop,
    .out_valid, .out_stall, .out_fb_address, .out_source, .out_tex_x,
    .out_tex_y, .out_flat_color, .out_depth, .out_last
  );
endmodule
`default_nettype wire
